// ===== sv/fba_pkg.sv =====
package fba_pkg;

  // Table geometry.
  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  // Fixed field widths of the request and result ports.
  localparam int SLOT_W  = 4;
  localparam int SIZE_W  = 16;
  localparam int COUNT_W = 5;

  // Derived widths.
  localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_BITS = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;

  // Configuration register indexes.
  localparam logic REG_FIT_MODE    = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // Request actions and fit modes.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;
  localparam logic MODE_FIRST  = 1'b0;
  localparam logic MODE_BEST   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic scan_en;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic used_zero;
    logic scan_last;
    logic first_hit;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/fit_block_allocator_unit.sv =====
// Channel   Direction  Handshake          Payload
// in        input      in_valid_i/stall   action_i, block_slot_i, size_value_i
// out       output     out_valid_o/stall  granted_o, chosen_block_o, left_over_o
// cfg       APB        psel/penable       fit_mode (0x0), block_count (0x4)
//
// A load request is written from the idle state and never stalls the input.
// An allocation request passes through a start step, a sequential scan of the
// free-size table over the blocks in use, and a write-back step. A first-fit hit
// ends the scan early.
// Reset clears the controller and the valid flags; the table holds no value
// until a block is loaded. A stalled result holds the write-back cycle only.
module fit_block_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [fba_pkg::SLOT_W-1:0]    block_slot_i,
  input  logic [fba_pkg::SIZE_W-1:0]    size_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          granted_o,
  output logic [fba_pkg::SLOT_W-1:0]    chosen_block_o,
  output logic [fba_pkg::SIZE_W-1:0]    left_over_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic                         fit_mode_q;
  logic [fba_pkg::COUNT_W-1:0]  block_count_q;
  logic                         busy;
  logic                         cfg_we;
  fba_pkg::ctrl_cmd_t           cmd;
  fba_pkg::dp_status_t          status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q    <= 1'b0;
      block_count_q <= fba_pkg::COUNT_W'(16);
    end else if (cfg_we) begin
      unique case (paddr[2])
        fba_pkg::REG_FIT_MODE:    fit_mode_q    <= pwdata[0];
        fba_pkg::REG_BLOCK_COUNT: block_count_q <= pwdata[fba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fba_pkg::REG_FIT_MODE:    prdata = 32'(fit_mode_q);
      fba_pkg::REG_BLOCK_COUNT: prdata = 32'(block_count_q);
      default:                  prdata = '0;
    endcase
  end

  assign in_stall_o = busy;

  fba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  fba_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .block_slot_i   (block_slot_i),
    .size_value_i   (size_value_i),
    .fit_mode_i     (fit_mode_q),
    .block_count_i  (block_count_q),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .granted_o      (granted_o),
    .chosen_block_o (chosen_block_o),
    .left_over_o    (left_over_o)
  );

endmodule

// ===== sv/fba_ctrl.sv =====
module fba_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   action_i,
  input  fba_pkg::dp_status_t    status_i,
  output fba_pkg::ctrl_cmd_t     cmd_o,
  output logic                   busy_o
);

  fba_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      fba_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == fba_pkg::ACT_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = fba_pkg::ST_SCAN;
          end
        end
      end
      fba_pkg::ST_SCAN: begin
        if (status_i.used_zero) begin
          state_d = fba_pkg::ST_FIN;
        end else begin
          cmd_o.scan_en = 1'b1;
          if (status_i.scan_last || status_i.first_hit) begin
            state_d = fba_pkg::ST_FIN;
          end
        end
      end
      fba_pkg::ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = fba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != fba_pkg::ST_IDLE);

endmodule

// ===== sv/fba_datapath.sv =====
module fba_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fba_pkg::ctrl_cmd_t            cmd_i,
  output fba_pkg::dp_status_t           status_o,
  input  logic [fba_pkg::SLOT_W-1:0]    block_slot_i,
  input  logic [fba_pkg::SIZE_W-1:0]    size_value_i,
  input  logic                          fit_mode_i,
  input  logic [fba_pkg::COUNT_W-1:0]   block_count_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic                          granted_o,
  output logic [fba_pkg::SLOT_W-1:0]    chosen_block_o,
  output logic [fba_pkg::SIZE_W-1:0]    left_over_o
);

  logic [fba_pkg::SIZE_BITS-1:0] table_q [fba_pkg::NUM_BLOCKS];

  logic [fba_pkg::SIZE_W-1:0]    size_q;
  logic                          mode_q;
  logic [fba_pkg::CNT_BITS-1:0]  used_q;
  logic [fba_pkg::IDX_BITS-1:0]  idx_q;
  logic                          found_q;
  logic [fba_pkg::IDX_BITS-1:0]  pick_q;
  logic [fba_pkg::SIZE_BITS-1:0] best_q;

  logic                          out_valid_q;
  logic                          granted_q;
  logic [fba_pkg::SLOT_W-1:0]    chosen_q;
  logic [fba_pkg::SIZE_W-1:0]    left_q;

  logic [fba_pkg::SIZE_BITS-1:0] entry;
  logic                          fits;
  logic                          take;
  logic [fba_pkg::CNT_BITS-1:0]  used_new;
  logic [fba_pkg::SIZE_BITS-1:0] remain;

  assign entry = table_q[idx_q];
  assign fits  = (fba_pkg::CMP_BITS'(entry) >= fba_pkg::CMP_BITS'(size_q));
  // Best fit replaces the candidate only on a strictly smaller size, so the
  // lowest index wins ties.
  assign take  = fits && (!found_q || ((mode_q == fba_pkg::MODE_BEST) && (entry < best_q)));
  assign remain = fba_pkg::SIZE_BITS'(fba_pkg::CMP_BITS'(best_q) - fba_pkg::CMP_BITS'(size_q));

  always_comb begin
    if (32'(block_count_i) > fba_pkg::NUM_BLOCKS) begin
      used_new = fba_pkg::CNT_BITS'(fba_pkg::NUM_BLOCKS);
    end else begin
      used_new = fba_pkg::CNT_BITS'(block_count_i);
    end
  end

  assign status_o.used_zero = (used_q == '0);
  assign status_o.scan_last = ((fba_pkg::CNT_BITS'(idx_q) + 1'b1) == used_q);
  assign status_o.first_hit = fits && (mode_q == fba_pkg::MODE_FIRST);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (32'(block_slot_i) < fba_pkg::NUM_BLOCKS)) begin
      table_q[fba_pkg::IDX_BITS'(block_slot_i)] <= fba_pkg::SIZE_BITS'(size_value_i);
    end else if (cmd_i.finish && found_q) begin
      table_q[pick_q] <= remain;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      size_q <= size_value_i;
      mode_q <= fit_mode_i;
      used_q <= used_new;
      idx_q  <= '0;
    end else if (cmd_i.scan_en) begin
      idx_q <= idx_q + 1'b1;
      if (take) begin
        pick_q <= idx_q;
        best_q <= entry;
      end
    end
    if (cmd_i.finish) begin
      granted_q <= found_q;
      chosen_q  <= found_q ? fba_pkg::SLOT_W'(pick_q) : '0;
      left_q    <= found_q ? fba_pkg::SIZE_W'(remain) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (cmd_i.scan_en && take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign chosen_block_o = chosen_q;
  assign left_over_o    = left_q;

endmodule

// ===== sv/fba_checker.sv =====
module fba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          action_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          granted_o,
  input logic [fba_pkg::SLOT_W-1:0]    chosen_block_o,
  input logic [fba_pkg::SIZE_W-1:0]    left_over_o
);

  // An allocation request always occupies the block for the scan.
  a_request_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && action_i == fba_pkg::ACT_REQUEST) |=> in_stall_o)
    else $error("allocation request did not stall the input");

  // A load request finishes in the cycle it is taken.
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && action_i == fba_pkg::ACT_LOAD) |=> !in_stall_o)
    else $error("load request stalled the input");

  // A new result only appears at the end of a request's processing.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> (chosen_block_o == '0 && left_over_o == '0))
    else $error("refused request reports a block or size");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(left_over_o)))
    else $error("stalled result changed");

endmodule

bind fit_block_allocator_unit fba_checker u_fba_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .action_i       (action_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .granted_o      (granted_o),
  .chosen_block_o (chosen_block_o),
  .left_over_o    (left_over_o)
);

// ===== tb/sv/fit_block_allocator_unit_test.sv =====
`timescale 1ns / 100ps

module fit_block_allocator_unit_test;

  typedef struct packed {
    logic                       action;
    logic [fba_pkg::SLOT_W-1:0] slot;
    logic [fba_pkg::SIZE_W-1:0] size;
  } alloc_req_t;

  typedef struct packed {
    logic                       granted;
    logic [fba_pkg::SLOT_W-1:0] chosen;
    logic [fba_pkg::SIZE_W-1:0] left;
  } alloc_res_t;

  localparam int DRAIN_CYCLES = 40;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       action_i = fba_pkg::ACT_LOAD;
  logic [fba_pkg::SLOT_W-1:0] block_slot_i = '0;
  logic [fba_pkg::SIZE_W-1:0] size_value_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       granted_o;
  logic [fba_pkg::SLOT_W-1:0] chosen_block_o;
  logic [fba_pkg::SIZE_W-1:0] left_over_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [2:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  fit_block_allocator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .block_slot_i   (block_slot_i),
    .size_value_i   (size_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_o      (granted_o),
    .chosen_block_o (chosen_block_o),
    .left_over_o    (left_over_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow of the allocator state and its configuration.
  logic [fba_pkg::SIZE_BITS-1:0] free_sizes [fba_pkg::NUM_BLOCKS];
  logic                          cfg_fit_mode = fba_pkg::MODE_FIRST;
  logic [fba_pkg::COUNT_W-1:0]   cfg_block_count = fba_pkg::COUNT_W'(16);

  alloc_req_t pending_reqs [$];
  alloc_res_t expected_grants [$];
  alloc_req_t cur_req;

  int unsigned push_cnt, accept_cnt, err_cnt;
  int unsigned load_cnt, alloc_cnt, grant_cnt, refuse_cnt, setting_cnt;
  int          send_idle_pct, recv_stall_pct;
  bit          hold_trig, hold_seen;
  int unsigned hold_left;

  function automatic void apply_request(input alloc_req_t r);
    alloc_res_t res;
    int         used;
    int         pick;
    bit         found;
    res = '0;
    pick = 0;
    found = 1'b0;
    if (r.action == fba_pkg::ACT_LOAD) begin
      if (r.slot < fba_pkg::NUM_BLOCKS) free_sizes[r.slot] = r.size[fba_pkg::SIZE_BITS-1:0];
      load_cnt++;
      return;
    end
    used = (cfg_block_count > fba_pkg::NUM_BLOCKS) ? fba_pkg::NUM_BLOCKS :
           int'(cfg_block_count);
    // First fit stops at the first hit; best fit keeps the strictly smaller one.
    for (int j = 0; j < used && !(found && cfg_fit_mode == fba_pkg::MODE_FIRST); j++) begin
      if (free_sizes[j] >= r.size && (!found || free_sizes[j] < free_sizes[pick])) begin
        pick = j;
        found = 1'b1;
      end
    end
    if (found) begin
      free_sizes[pick] = free_sizes[pick] - r.size;
      res.granted = 1'b1;
      res.chosen = fba_pkg::SLOT_W'(pick);
      res.left = free_sizes[pick];
    end
    alloc_cnt++;
    expected_grants.push_back(res);
  endfunction

  always @(posedge clk_i) begin : drive_proc
    logic busy_hold;
    busy_hold = in_valid_i && in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_request(cur_req);
        accept_cnt++;
      end
      if (!busy_hold) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          action_i <= cur_req.action;
          block_slot_i <= cur_req.slot;
          size_value_i <= cur_req.size;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by toggling hold_trig.
  always @(posedge clk_i) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : watch_proc
    alloc_res_t exp_res;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_grants.size() == 0) begin
          $error("unexpected result: granted %0d chosen_block %0d left_over %0d",
                 granted_o, chosen_block_o, left_over_o);
          err_cnt++;
        end else begin
          exp_res = expected_grants.pop_front();
          if (exp_res.granted) grant_cnt++;
          else refuse_cnt++;
          if (granted_o !== exp_res.granted) begin
            $error("granted: expected %0d, got %0d", exp_res.granted, granted_o);
            err_cnt++;
          end
          if (chosen_block_o !== exp_res.chosen) begin
            $error("chosen_block: expected %0d, got %0d", exp_res.chosen, chosen_block_o);
            err_cnt++;
          end
          if (left_over_o !== exp_res.left) begin
            $error("left_over: expected %0d, got %0d", exp_res.left, left_over_o);
            err_cnt++;
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic add_item(input logic act, input logic [fba_pkg::SLOT_W-1:0] slot,
                          input logic [fba_pkg::SIZE_W-1:0] size);
    alloc_req_t r;
    r.action = act;
    r.slot = slot;
    r.size = size;
    pending_reqs.push_back(r);
    push_cnt++;
  endtask

  task automatic add_random(input int n);
    logic [fba_pkg::SIZE_W-1:0] sz;
    int                         roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        case ($urandom_range(9))
          0: sz = '0;
          1: sz = '1;
          2, 3, 4: sz = fba_pkg::SIZE_W'($urandom);
          default: sz = fba_pkg::SIZE_W'($urandom_range(4095));
        endcase
        add_item(fba_pkg::ACT_LOAD,
                 fba_pkg::SLOT_W'($urandom_range(fba_pkg::NUM_BLOCKS - 1)), sz);
      end else begin
        // Mostly small requests so that several fit before the table runs dry.
        case ($urandom_range(19))
          0: sz = '0;
          1: sz = '1;
          2, 3: sz = fba_pkg::SIZE_W'($urandom);
          4, 5, 6, 7, 8: sz = fba_pkg::SIZE_W'($urandom_range(16383));
          default: sz = fba_pkg::SIZE_W'($urandom_range(1023));
        endcase
        add_item(fba_pkg::ACT_REQUEST, fba_pkg::SLOT_W'($urandom), sz);
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (accept_cnt != push_cnt || expected_grants.size() != 0);
    // A load leaves nothing to wait for, so give the block time to settle.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == fba_pkg::REG_FIT_MODE) cfg_fit_mode = val[0];
    else cfg_block_count = val[fba_pkg::COUNT_W-1:0];
  endtask

  task automatic set_phase(input logic mode, input logic [fba_pkg::COUNT_W-1:0] count,
                           input int send_pct, input int recv_pct);
    wait_drained();
    cfg_write(fba_pkg::REG_FIT_MODE, 32'(mode));
    cfg_write(fba_pkg::REG_BLOCK_COUNT, 32'(count));
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    setting_cnt++;
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every block is loaded before the first request so no search sees an
    // entry that was never written.
    set_phase(fba_pkg::MODE_FIRST, fba_pkg::COUNT_W'(16), 0, 0);
    add_item(fba_pkg::ACT_LOAD, 0, 0);
    add_item(fba_pkg::ACT_LOAD, 1, 100);
    add_item(fba_pkg::ACT_LOAD, 2, 16'hFFFF);
    add_item(fba_pkg::ACT_LOAD, 3, 50);
    add_item(fba_pkg::ACT_LOAD, 4, 100);
    add_item(fba_pkg::ACT_LOAD, 5, 1);
    for (int s = 6; s < 15; s++) begin
      add_item(fba_pkg::ACT_LOAD, fba_pkg::SLOT_W'(s), 16'(s * 100));
    end
    add_item(fba_pkg::ACT_LOAD, 15, 16'h8000);
    add_item(fba_pkg::ACT_REQUEST, 0, 0);
    add_item(fba_pkg::ACT_REQUEST, 0, 16'hFFFF);
    add_item(fba_pkg::ACT_REQUEST, 15, 16'hFFFF);
    add_item(fba_pkg::ACT_REQUEST, 0, 60);
    add_random(200);

    // Best fit with a tie between two full-size blocks.
    set_phase(fba_pkg::MODE_BEST, fba_pkg::COUNT_W'(16), 74, 0);
    add_item(fba_pkg::ACT_LOAD, 9, 16'hFFFF);
    add_item(fba_pkg::ACT_LOAD, 4, 16'hFFFF);
    add_item(fba_pkg::ACT_REQUEST, 0, 16'hFFFF);
    add_item(fba_pkg::ACT_REQUEST, 0, 16'hFFFF);
    add_random(150);

    // No block in use: every allocation request is refused.
    set_phase(fba_pkg::MODE_BEST, fba_pkg::COUNT_W'(0), 0, 74);
    add_item(fba_pkg::ACT_REQUEST, 0, 0);
    add_item(fba_pkg::ACT_REQUEST, 0, 1);
    add_random(60);

    // A count beyond the table, with a sender pause halfway.
    set_phase(fba_pkg::MODE_FIRST, fba_pkg::COUNT_W'(31), 22, 22);
    add_random(75);
    wait_drained();
    add_random(75);

    set_phase(fba_pkg::MODE_BEST, fba_pkg::COUNT_W'(1), 0, 74);
    add_random(100);

    // The receiver holds off while the sender keeps offering requests.
    set_phase(fba_pkg::MODE_FIRST, fba_pkg::COUNT_W'($urandom_range(2, 15)), 0, 0);
    hold_trig = ~hold_trig;
    add_random(120);

    set_phase(fba_pkg::MODE_BEST, fba_pkg::COUNT_W'($urandom_range(17, 30)), 22, 22);
    add_random(150);

    wait_drained();
    $display("run covered %0d loads and %0d allocation requests (%0d granted, %0d refused)",
             load_cnt, alloc_cnt, grant_cnt, refuse_cnt);
    $display("over %0d settings of fit mode and block count, with and without idling",
             setting_cnt);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $error("timeout: %0d requests not accepted, %0d results outstanding",
           push_cnt - accept_cnt, expected_grants.size());
    $display("tb: failure");
    $finish;
  end

endmodule
